[design/bda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// shared constants of the block average downscaler: register map, register
// widths and reset values, gain format, block sum guard and parameter defaults
// ----------------------------------------------------------------------------
package bda_pkg;

  // register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_GAIN   = 2'd2;

  // register widths
  localparam int SIDE_REG_W  = 11;
  localparam int BLOCK_REG_W = 5;
  localparam int GAIN_W      = 24;

  // reset values
  localparam logic [SIDE_REG_W-1:0]   SIDE_RESET  = 11'd64;
  localparam logic [BLOCK_REG_W-1:0]  BLOCK_RESET = 5'd2;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd262144;

  // gain is Q3.20
  localparam int GAIN_FRAC = 20;

  // guard on the block sum before the multiply, +-(2^40 - 1)
  localparam int SUM_LIMIT_W = 41;
  localparam logic [SUM_LIMIT_W-1:0] SUM_LIMIT = 41'h0FF_FFFF_FFFF;

  // parameter defaults
  localparam int MAX_SIDE_DEF    = 1024;
  localparam int MAX_BLOCK_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

endpackage

[design/bda_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_ram
// generic simple dual port ram, one write port, one read port with
// registered read data
// ----------------------------------------------------------------------------
module bda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/block_average_downscale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_downscale
// sums each non-overlapping b x b block of a square raster lattice and
// emits the block sum times a gain, rounded and saturated
// ----------------------------------------------------------------------------
// usage
//   input: in_valid / in_stall, one signed sample per item in raster order,
//   row by row, taken at a rising edge with in_valid high and in_stall low.
//   output: out_valid / out_stall with coarse_sample and frame_end, one item
//   on the last sample of every complete block; frame_end marks the last
//   complete block of the lattice.
//   config: cfg_we / cfg_index / cfg_data, written while idle; writing
//   lattice_side or block_size restarts the frame.
// timing
//   one item per clock while out_stall does not back up into stage 1. a
//   result passes accumulate and clamp, partial products, then round into
//   the output register. the column sum ram read-modify-write sets the
//   rate, with a last-write bypass for back-to-back items of the same block
//   column.
// reset: geometry and gain return to 64 / 2 / 0.25, counters to zero; the
//   ram is not cleared since the first sample of a block overwrites its entry
// stall: a stalled result holds; three results wait in the stages behind it,
//   and in_stall rises only while the last sample of a block finds no room
// ----------------------------------------------------------------------------
module block_average_downscale #(
  parameter int MAX_SIDE    = bda_pkg::MAX_SIDE_DEF,
  parameter int MAX_BLOCK   = bda_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = bda_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample items
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  // coarse items
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         coarse_sample,
  output logic                                  frame_end,
  // config
  input  logic                                  cfg_we,
  input  logic [bda_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int GAIN_W  = bda_pkg::GAIN_W;
  localparam int CNT_W   = $clog2(MAX_SIDE);
  localparam int OFF_W   = $clog2(MAX_BLOCK);
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int BLK_W   = $clog2(MAX_BLOCK + 1);
  localparam int EDGE_W  = ((SIDE_W > BLK_W) ? SIDE_W : BLK_W) + 1;
  // a block holds up to MAX_BLOCK^2 samples
  localparam int SUM_W   = SAMPLE_BITS + 2 * $clog2(MAX_BLOCK);
  localparam int MUL_W   = (SUM_W > bda_pkg::SUM_LIMIT_W) ? bda_pkg::SUM_LIMIT_W : SUM_W;
  localparam int EXT_W   = (SUM_W > bda_pkg::SUM_LIMIT_W) ? SUM_W : bda_pkg::SUM_LIMIT_W + 1;
  localparam int LO_W    = MUL_W / 2;
  localparam int HI_W    = MUL_W - LO_W;
  localparam int PP_LO_W = LO_W + 1 + GAIN_W;
  localparam int PP_HI_W = HI_W + GAIN_W;
  localparam int P_W     = MUL_W + GAIN_W + 1;
  localparam int R_W     = P_W - bda_pkg::GAIN_FRAC;

  localparam logic signed [EXT_W-1:0] SUM_LIM = EXT_W'(bda_pkg::SUM_LIMIT);
  localparam logic signed [P_W-1:0]   RND     = P_W'(1) <<< (bda_pkg::GAIN_FRAC - 1);
  localparam logic signed [R_W-1:0]   OUT_MAX =
    R_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [R_W-1:0]   OUT_MIN = -OUT_MAX - R_W'(1);

  // registers
  logic [bda_pkg::SIDE_REG_W-1:0]  lattice_side;
  logic [bda_pkg::BLOCK_REG_W-1:0] block_size;
  logic signed [GAIN_W-1:0]        block_gain;

  // effective geometry after zero / upper clamps
  logic [SIDE_W-1:0] side_eff;
  logic [BLK_W-1:0]  blk_eff;

  always_comb begin
    if (lattice_side == '0) begin
      side_eff = SIDE_W'(1);
    end else if (32'(lattice_side) > 32'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(lattice_side);
    end
    if (block_size == '0) begin
      blk_eff = BLK_W'(1);
    end else if (32'(block_size) > 32'(MAX_BLOCK)) begin
      blk_eff = BLK_W'(MAX_BLOCK);
    end else begin
      blk_eff = BLK_W'(block_size);
    end
  end

  // raster position
  logic [CNT_W-1:0] col, row, bcol;
  logic [OFF_W-1:0] ocol, orow;

  // pipeline control
  logic accept;
  logic s1_valid, s1_done, s1_free;
  logic s2_valid, s2_free;
  logic s3_valid, s3_free;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s1_done;
  assign accept   = in_valid && s1_free;
  assign in_stall = !s1_free;

  // position decode for the incoming item
  logic col_wrap, row_wrap, ocol_wrap, orow_wrap;
  logic in_first, in_emit, in_last;

  always_comb begin
    col_wrap  = SIDE_W'(col) == side_eff - SIDE_W'(1);
    row_wrap  = SIDE_W'(row) == side_eff - SIDE_W'(1);
    ocol_wrap = BLK_W'(ocol) == blk_eff - BLK_W'(1);
    orow_wrap = BLK_W'(orow) == blk_eff - BLK_W'(1);
    in_first  = (ocol == '0) && (orow == '0);
    // a partial block never reaches its last offset, so this is enough
    in_emit   = ocol_wrap && orow_wrap;
    // no further complete block fits right of / below this one
    in_last   = (EDGE_W'(col) + EDGE_W'(blk_eff) >= EDGE_W'(side_eff)) &&
                (EDGE_W'(row) + EDGE_W'(blk_eff) >= EDGE_W'(side_eff));
  end

  logic geo_write;
  assign geo_write = cfg_we && ((cfg_index == bda_pkg::CFG_LATTICE_SIDE) ||
                                (cfg_index == bda_pkg::CFG_BLOCK_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_side <= bda_pkg::SIDE_RESET;
      block_size   <= bda_pkg::BLOCK_RESET;
      block_gain   <= bda_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bda_pkg::CFG_LATTICE_SIDE: lattice_side <= cfg_data[bda_pkg::SIDE_REG_W-1:0];
        bda_pkg::CFG_BLOCK_SIZE:   block_size   <= cfg_data[bda_pkg::BLOCK_REG_W-1:0];
        bda_pkg::CFG_BLOCK_GAIN:   block_gain   <= $signed(cfg_data[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // raster counters, restarted by a geometry write
  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      col  <= '0;
      row  <= '0;
      bcol <= '0;
      ocol <= '0;
      orow <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col  <= '0;
        bcol <= '0;
        ocol <= '0;
        if (row_wrap) begin
          row  <= '0;
          orow <= '0;
        end else begin
          row  <= row + CNT_W'(1);
          orow <= orow_wrap ? '0 : orow + OFF_W'(1);
        end
      end else begin
        col <= col + CNT_W'(1);
        if (ocol_wrap) begin
          ocol <= '0;
          bcol <= bcol + CNT_W'(1);
        end else begin
          ocol <= ocol + OFF_W'(1);
        end
      end
    end
  end

  // stage 1: column sum read-modify-write
  logic [CNT_W-1:0]             s1_addr;
  logic                         s1_first, s1_emit, s1_last;
  logic signed [SAMPLE_BITS-1:0] s1_x;

  logic [SUM_W-1:0] ram_rdata;
  logic             ram_we;

  // last write, bypassed when the ram read raced it
  logic             lw_valid;
  logic [CNT_W-1:0] lw_addr;
  logic [SUM_W-1:0] lw_data;

  logic signed [SUM_W-1:0] acc_base, acc;

  assign s1_done = s1_valid && (!s1_emit || s2_free);
  assign ram_we  = s1_done;

  always_comb begin
    if (s1_first) begin
      acc_base = '0;
    end else if (lw_valid && (lw_addr == s1_addr)) begin
      acc_base = $signed(lw_data);
    end else begin
      acc_base = $signed(ram_rdata);
    end
    acc = acc_base + SUM_W'(s1_x);
  end

  bda_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SIDE)
  ) u_column_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (acc),
    .re    (accept),
    .raddr (bcol),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (ram_we) begin
        lw_valid <= 1'b1;
      end
    end
    if (accept) begin
      s1_addr  <= bcol;
      s1_first <= in_first;
      s1_emit  <= in_emit;
      s1_last  <= in_last;
      s1_x     <= sample;
    end
    if (ram_we) begin
      lw_addr <= s1_addr;
      lw_data <= acc;
    end
  end

  // stage 2: guarded block sum
  logic signed [EXT_W-1:0] acc_ext, acc_clamp;
  logic signed [MUL_W-1:0] s2_sum;
  logic                    s2_last;

  always_comb begin
    acc_ext = EXT_W'(acc);
    if (acc_ext > SUM_LIM) begin
      acc_clamp = SUM_LIM;
    end else if (acc_ext < -SUM_LIM) begin
      acc_clamp = -SUM_LIM;
    end else begin
      acc_clamp = acc_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_done && s1_emit) begin
      s2_valid <= 1'b1;
    end else if (s3_free) begin
      s2_valid <= 1'b0;
    end
    if (s1_done && s1_emit) begin
      s2_sum  <= $signed(acc_clamp[MUL_W-1:0]);
      s2_last <= s1_last;
    end
  end

  // stage 3: two partial products of sum times gain
  logic signed [PP_LO_W-1:0] pp_lo;
  logic signed [PP_HI_W-1:0] pp_hi;
  logic                      s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_valid && s3_free) begin
      s3_valid <= 1'b1;
    end else if (out_free) begin
      s3_valid <= 1'b0;
    end
    if (s2_valid && s3_free) begin
      pp_lo   <= $signed({1'b0, s2_sum[LO_W-1:0]}) * block_gain;
      pp_hi   <= $signed(s2_sum[MUL_W-1:LO_W]) * block_gain;
      s3_last <= s2_last;
    end
  end

  // output register: combine, round half up, saturate
  logic signed [P_W-1:0] prod;
  logic signed [R_W-1:0] rounded, sat;

  always_comb begin
    prod    = (P_W'(pp_hi) <<< LO_W) + P_W'(pp_lo) + RND;
    rounded = $signed(prod[P_W-1:bda_pkg::GAIN_FRAC]);
    if (rounded > OUT_MAX) begin
      sat = OUT_MAX;
    end else if (rounded < OUT_MIN) begin
      sat = OUT_MIN;
    end else begin
      sat = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s3_valid && out_free) begin
      coarse_sample <= $signed(sat[SAMPLE_BITS-1:0]);
      frame_end     <= s3_last;
    end
  end

  // checks
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty accumulate stage");

  a_emit_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && !s2_free |=> s1_valid)
    else $error("block result dropped while the next stage was full");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s3_free |=> s2_valid && $stable(s2_sum))
    else $error("guarded sum changed while blocked");

  a_offsets: assert property (@(posedge clk) disable iff (rst)
    (BLK_W'(ocol) < blk_eff) && (BLK_W'(orow) < blk_eff))
    else $error("block offset outside the block");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    geo_write |=> (col == '0) && (row == '0) && (ocol == '0) && (orow == '0) &&
                  (bcol == '0))
    else $error("geometry write did not restart the frame");

endmodule
